// ===== design/aen_pkg.sv =====
`timescale 1ns / 1ps

package aen_pkg;

    // Envelope extremes are Q16.16 in a signed 32-bit word
    localparam int ENV_BITS   = 32;
    localparam int SPAN_BITS  = ENV_BITS + 1;
    localparam int REM_BITS   = ENV_BITS + 2;
    localparam int NORM_BITS  = 16;
    localparam int ALPHA_BITS = 16;
    localparam int PROD_BITS  = ENV_BITS + ALPHA_BITS;
    localparam int QUO_BITS   = 17;
    localparam int DIV_STEPS  = QUO_BITS - 1;
    localparam int CNT_BITS   = $clog2(DIV_STEPS);

    localparam logic signed [NORM_BITS-1:0] NORM_POS_FULL = {1'b0, {(NORM_BITS-1){1'b1}}};

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic load;     // take the sample, widen the extremes
        logic span;     // form span and offset, seed the divider
        logic step;     // one restoring-divide step, refresh the decay product
        logic commit;   // write the result, pull the extremes inward
    } t_aen_cmd;

    // Status from the datapath to the sequencer
    typedef struct packed {
        logic out_free;
        logic cfg_busy;
    } t_aen_stat;

endpackage

// ===== design/aen_ctrl.sv =====
`timescale 1ns / 1ps

module aen_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  aen_pkg::t_aen_stat  i_stat,
    output aen_pkg::t_aen_cmd   o_cmd
);
    import aen_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SPAN,
        ST_DIV,
        ST_FIN
    } t_state;

    t_state                r_state;
    logic [CNT_BITS-1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    // advance only on an accepted request
                    if (i_in_valid && !i_stat.cfg_busy) begin
                        r_state <= ST_SPAN;
                    end
                end
                ST_SPAN: begin
                    r_cnt   <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_BITS'(DIV_STEPS - 1)) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    // hold until the output register can take the result
                    if (i_stat.out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = (r_state == ST_IDLE) && !i_stat.cfg_busy;
        unique case (r_state)
            ST_IDLE: o_cmd.load   = i_in_valid && !i_stat.cfg_busy;
            ST_SPAN: o_cmd.span   = 1'b1;
            ST_DIV:  o_cmd.step   = 1'b1;
            ST_FIN:  o_cmd.commit = i_stat.out_free;
            default: o_cmd        = '0;
        endcase
    end

endmodule

// ===== design/aen_dp.sv =====
`timescale 1ns / 1ps

module aen_dp #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  aen_pkg::t_aen_cmd                      i_cmd,
    output aen_pkg::t_aen_stat                     o_stat,
    input  logic                                   i_cfg_valid,
    input  logic [aen_pkg::ALPHA_BITS-1:0]         i_cfg_data,
    input  logic signed [SAMPLE_BITS-1:0]          i_sample,
    input  logic                                   i_out_ready,
    output logic                                   o_out_valid,
    output logic signed [aen_pkg::NORM_BITS-1:0]   o_norm,
    output logic                                   o_span_ok
);
    import aen_pkg::*;

    localparam int EXT_BITS = (SAMPLE_BITS + FRAC_BITS > ENV_BITS) ?
                              (SAMPLE_BITS + FRAC_BITS) : (ENV_BITS + 1);
    localparam logic signed [EXT_BITS-1:0] EXT_HI =
        {{(EXT_BITS-ENV_BITS+1){1'b0}}, {(ENV_BITS-1){1'b1}}};
    localparam logic signed [EXT_BITS-1:0] EXT_LO =
        {{(EXT_BITS-ENV_BITS+1){1'b1}}, {(ENV_BITS-1){1'b0}}};
    localparam logic signed [ENV_BITS-1:0] ENV_HI = {1'b0, {(ENV_BITS-1){1'b1}}};
    localparam logic signed [ENV_BITS-1:0] ENV_LO = {1'b1, {(ENV_BITS-1){1'b0}}};

    function automatic logic signed [ENV_BITS-1:0] sat_env(
        input logic signed [REM_BITS-1:0] v
    );
        logic signed [REM_BITS-1:0] hi;
        logic signed [REM_BITS-1:0] lo;
        hi = REM_BITS'(ENV_HI);
        lo = REM_BITS'(ENV_LO);
        if (v > hi) begin
            return ENV_HI;
        end else if (v < lo) begin
            return ENV_LO;
        end
        return v[ENV_BITS-1:0];
    endfunction

    // state and control registers
    logic signed [ENV_BITS-1:0]   r_max;
    logic signed [ENV_BITS-1:0]   r_min;
    logic [ALPHA_BITS-1:0]        r_alpha;
    logic                         r_out_valid;
    logic                         r_cfg_seen;

    // working registers
    logic signed [ENV_BITS-1:0]   r_s;
    logic signed [SPAN_BITS-1:0]  r_span;
    logic [REM_BITS-1:0]          r_rem;
    logic [QUO_BITS-1:0]          r_quo;
    logic [PROD_BITS-1:0]         r_prod;
    logic signed [NORM_BITS-1:0]  r_norm;
    logic                         r_span_ok;

    logic signed [EXT_BITS-1:0]   w_ext;
    logic signed [EXT_BITS-1:0]   w_ext_sh;
    logic signed [ENV_BITS-1:0]   w_s;
    logic signed [SPAN_BITS-1:0]  w_span;
    logic signed [SPAN_BITS-1:0]  w_ofs;
    logic                         w_seed_ge;
    logic [REM_BITS-1:0]          w_rem_sh;
    logic [REM_BITS-1:0]          w_div;
    logic                         w_step_ge;
    logic signed [SPAN_BITS-1:0]  w_span_neg;
    logic [ENV_BITS-1:0]          w_mag;
    logic signed [REM_BITS-1:0]   w_delta;
    logic signed [REM_BITS-1:0]   w_max_x;
    logic signed [REM_BITS-1:0]   w_min_x;
    logic signed [ENV_BITS-1:0]   w_max_new;
    logic signed [ENV_BITS-1:0]   w_min_new;
    logic                         w_span_pos;
    logic signed [NORM_BITS-1:0]  w_norm;

    // sample to Q16.16 with saturation
    always_comb begin
        w_ext    = EXT_BITS'(i_sample);
        w_ext_sh = w_ext <<< FRAC_BITS;
        if (w_ext_sh > EXT_HI) begin
            w_s = ENV_HI;
        end else if (w_ext_sh < EXT_LO) begin
            w_s = ENV_LO;
        end else begin
            w_s = w_ext_sh[ENV_BITS-1:0];
        end
    end

    // span, offset and divider seed
    always_comb begin
        w_span    = SPAN_BITS'(r_max) - SPAN_BITS'(r_min);
        w_ofs     = SPAN_BITS'(r_s) - SPAN_BITS'(r_min);
        w_seed_ge = (w_ofs >= w_span);
        w_rem_sh  = {r_rem[REM_BITS-2:0], 1'b0};
        w_div     = {1'b0, r_span};
        w_step_ge = (w_rem_sh >= w_div);
    end

    // decay: pull the extremes inward by |span| * alpha, signed as span; map the quotient to Q1.15
    always_comb begin
        w_span_neg = -r_span;
        w_mag      = r_span[SPAN_BITS-1] ? w_span_neg[ENV_BITS-1:0] : r_span[ENV_BITS-1:0];
        w_delta    = REM_BITS'({2'b00, r_prod[PROD_BITS-1:ALPHA_BITS]});
        w_max_x    = REM_BITS'(r_max);
        w_min_x    = REM_BITS'(r_min);
        if (r_span[SPAN_BITS-1]) begin
            w_max_new = sat_env(w_max_x + w_delta);
            w_min_new = sat_env(w_min_x - w_delta);
        end else begin
            w_max_new = sat_env(w_max_x - w_delta);
            w_min_new = sat_env(w_min_x + w_delta);
        end
        w_span_pos = !r_span[SPAN_BITS-1] && (r_span != '0);
        if (!w_span_pos) begin
            w_norm = '0;
        end else if (r_quo[QUO_BITS-1]) begin
            w_norm = NORM_POS_FULL;
        end else begin
            w_norm = {~r_quo[NORM_BITS-1], r_quo[NORM_BITS-2:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max       <= '0;
            r_min       <= '0;
            r_alpha     <= '0;
            r_out_valid <= 1'b0;
            r_cfg_seen  <= 1'b0;
        end else begin
            r_cfg_seen <= i_cfg_valid;
            if (i_cfg_valid) begin
                r_alpha <= i_cfg_data;
            end
            if (i_cmd.load) begin
                if (w_s > r_max) begin
                    r_max <= w_s;
                end
                if (w_s < r_min) begin
                    r_min <= w_s;
                end
            end else if (i_cmd.commit) begin
                r_max <= w_max_new;
                r_min <= w_min_new;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_s <= w_s;
        end
        if (i_cmd.span) begin
            r_span <= w_span;
            r_rem  <= w_seed_ge ? REM_BITS'(w_ofs - w_span) : REM_BITS'(w_ofs);
            r_quo  <= {{(QUO_BITS-1){1'b0}}, w_seed_ge};
        end
        if (i_cmd.step) begin
            r_rem  <= w_step_ge ? (w_rem_sh - w_div) : w_rem_sh;
            r_quo  <= {r_quo[QUO_BITS-2:0], w_step_ge};
            r_prod <= PROD_BITS'(w_mag) * PROD_BITS'(r_alpha);
        end
        if (i_cmd.commit) begin
            r_norm    <= w_norm;
            r_span_ok <= w_span_pos;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_stat.cfg_busy = r_cfg_seen;
    assign o_out_valid     = r_out_valid;
    assign o_norm          = r_norm;
    assign o_span_ok       = r_span_ok;

endmodule

// ===== design/ask_envelope_normalizer_top.sv =====
`timescale 1ns / 1ps

// Decaying min/max envelope normalizer.
// Input stream (s_axis_*): one signed sample per request in tdata. Each
// sample widens a running Q16.16 max/min envelope, is mapped onto [-1, +1)
// as a Q1.15 value, and then both extremes pull toward each other by
// span * decay_rate.
// Output stream (m_axis_*): one request per sample, norm_out in tdata and
// span_valid in tuser; tuser low means the span was not positive and
// tdata is zero.
// Configuration (i_cfg_*): write decay_rate (alpha, Q0.16) while idle;
// o_cfg_ready is always high.
// After input acceptance a sample passes one span step, 16 steps of the
// restoring divider and one commit, which waits for a free output register.
// A new sample is taken only once the last one is through the shared
// bit-serial divider; the input is taken again as soon as the result is in
// the output register, so a waiting receiver costs nothing until the next
// result is ready. If the receiver stalls, hold the finished result in the
// sequencer and the output register; no result is dropped.
// Reset: synchronous, active low; clears both extremes and decay_rate.
module ask_envelope_normalizer_top #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // config write: decay_rate in [15:0]
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [aen_pkg::ALPHA_BITS-1:0]        i_cfg_data,
    // input stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,   // sample_in
    // output stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [aen_pkg::NORM_BITS-1:0]         m_axis_tdata,   // norm_out
    output logic [0:0]                            m_axis_tuser    // span_valid
);
    import aen_pkg::*;

    t_aen_cmd                    w_cmd;
    t_aen_stat                   w_stat;
    logic signed [NORM_BITS-1:0] w_norm;
    logic                        w_span_ok;

    assign o_cfg_ready = 1'b1;

    // sequencer: accept, span, divide, commit
    aen_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // envelope registers, divider, decay multiplier and output register
    aen_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_sample    (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_norm      (w_norm),
        .o_span_ok   (w_span_ok)
    );

    assign m_axis_tdata    = w_norm;
    assign m_axis_tuser[0] = w_span_ok;

    // one sample in flight: the input closes right after acceptance
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while a sample is in flight");

    // a result without a valid span carries zero
    a_zero_when_no_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("nonzero output with no positive span");

    // a new result appears only at the end of a sample's processing
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared while the block was idle");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

// Stream test for the decaying min/max envelope normalizer.
module tb;

    import aen_pkg::*;

    localparam int CLK_HALF   = 10;
    localparam int RST_CYCLES = 6;
    localparam int SETTLE     = 25;
    localparam int HOLD_LEN   = 400;    // long receiver hold-off, in cycles

    // Expected contents of one output request
    typedef struct {
        logic [NORM_BITS-1:0] norm;
        logic                 span_ok;
    } t_norm_result;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [ALPHA_BITS-1:0]          i_cfg_data = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [15:0]                    s_axis_tdata = '0;      // sample_in
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [NORM_BITS-1:0]           m_axis_tdata;           // norm_out
    logic [0:0]                     m_axis_tuser;           // span_valid

    ask_envelope_normalizer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Envelope state mirrored from the block, plus the decay register
    longint               env_hi = 0;
    longint               env_lo = 0;
    logic [ALPHA_BITS-1:0] decay_alpha = '0;

    logic [15:0]   sample_q[$];         // samples waiting for the driver
    t_norm_result  norm_expect_q[$];    // results still owed by the block

    int items_pushed    = 0;
    int results_checked = 0;
    int err_count       = 0;

    // Driver and receiver bookkeeping
    int burst_left = 0;
    int gap_left   = 0;
    logic next_valid;
    int hold_left  = 0;
    int rx_count   = 0;
    int rx_cycle   = 0;
    logic next_ready;
    t_norm_result got_exp;

    function automatic longint env_clamp(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Widen the envelope with one sample, map the sample onto [-1, +1) in Q1.15,
    // then pull both extremes inward by span * alpha.
    function automatic t_norm_result envelope_predict(input logic signed [15:0] smp);
        longint s, span, mag, delta, nv;
        longint unsigned num, ratio;
        t_norm_result res;
        s = env_clamp(longint'(smp) * 65536);
        if (s > env_hi) env_hi = s;
        if (s < env_lo) env_lo = s;
        span = env_hi - env_lo;
        if (span > 0) begin
            num   = $unsigned(s - env_lo) << 16;
            ratio = num / $unsigned(span);
            nv    = longint'(ratio) - 32768;
            if (nv > 32767) nv = 32767;     // +1.0 saturates
            res.span_ok = 1'b1;
        end else begin
            nv = 0;
            res.span_ok = 1'b0;
        end
        // The decay still runs on a negative span and pulls the extremes toward each other
        mag   = (span < 0) ? -span : span;
        delta = longint'(($unsigned(mag) * longint'(decay_alpha)) >> 16);
        if (span < 0) delta = -delta;
        env_hi = env_clamp(env_hi - delta);
        env_lo = env_clamp(env_lo + delta);
        res.norm = nv[NORM_BITS-1:0];
        return res;
    endfunction

    // Driver: offer samples in bursts of random length with random gaps.
    // Predict each sample at the edge where it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                norm_expect_q.push_back(envelope_predict(s_axis_tdata));
            end
            // Hold the current request until it is taken
            if (!s_axis_tvalid || s_axis_tready) begin
                next_valid = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (sample_q.size() > 0) begin
                    s_axis_tdata <= sample_q.pop_front();
                    next_valid = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
                    end
                end
                s_axis_tvalid <= next_valid;
            end
        end
    end

    // Receiver: check each result against the oldest expectation and stall on
    // one of four patterns, taken in turn as the run goes on. Twice during the
    // run, hold off for a long stretch so the block backs up into its input.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            rx_cycle++;
            if (m_axis_tvalid && m_axis_tready) begin
                if (norm_expect_q.size() == 0) begin
                    $error("unexpected result: norm_out %0d span_valid %0d",
                           $signed(m_axis_tdata), m_axis_tuser);
                    err_count++;
                end else begin
                    got_exp = norm_expect_q.pop_front();
                    results_checked++;
                    if (m_axis_tdata !== got_exp.norm) begin
                        $error("norm_out mismatch: expected %0d, got %0d",
                               $signed(got_exp.norm), $signed(m_axis_tdata));
                        err_count++;
                    end
                    if (m_axis_tuser[0] !== got_exp.span_ok) begin
                        $error("span_valid mismatch: expected %0d, got %0d",
                               got_exp.span_ok, m_axis_tuser[0]);
                        err_count++;
                    end
                end
                rx_count++;
                if (rx_count == 60 || rx_count == 500) hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                next_ready = 1'b0;
            end else begin
                case ((rx_cycle / 200) % 4)
                    0: next_ready = 1'b1;
                    1: next_ready = ($urandom_range(0, 99) < 50);
                    2: next_ready = ((rx_cycle % 3) == 0);
                    default: next_ready = ($urandom_range(0, 99) < 85);
                endcase
            end
            m_axis_tready <= next_ready;
        end
    end

    task automatic add_sample(input int v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        sample_q.push_back(v[15:0]);
        items_pushed++;
    endtask

    // Wait until every request has come back, then let the pipeline settle
    task automatic drain();
        while (results_checked != items_pushed) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Write decay_rate; only called while the block is idle
    task automatic write_decay(input logic [ALPHA_BITS-1:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        decay_alpha = v;
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly on-off keyed bursts with noise and offset, the rest uniform noise,
    // constant runs and a mix of full-scale, zero and -1 values.
    task automatic gen_signal(input int n);
        int cnt, kind, amp, ofs, nsym, len, noise, lvl;
        cnt = 0;
        while (cnt < n) begin
            kind = $urandom_range(0, 9);
            if (kind < 6) begin
                amp   = $urandom_range(50, 32767);
                if ($urandom_range(0, 1)) amp = -amp;
                ofs   = int'($urandom_range(0, 2000)) - 1000;
                noise = (amp < 0 ? -amp : amp) / 16 + 1;
                nsym  = $urandom_range(2, 8);
                for (int k = 0; k < nsym; k++) begin
                    lvl = $urandom_range(0, 1) ? amp : 0;
                    len = $urandom_range(2, 10);
                    for (int j = 0; j < len && cnt < n; j++) begin
                        add_sample(ofs + lvl + int'($urandom_range(0, 2 * noise)) - noise);
                        cnt++;
                    end
                end
            end else if (kind < 8) begin
                len = $urandom_range(1, 10);
                for (int j = 0; j < len && cnt < n; j++) begin
                    add_sample(int'($urandom_range(0, 65535)) - 32768);
                    cnt++;
                end
            end else if (kind == 8) begin
                lvl = int'($urandom_range(0, 65535)) - 32768;
                len = $urandom_range(2, 12);
                for (int j = 0; j < len && cnt < n; j++) begin
                    add_sample(lvl);
                    cnt++;
                end
            end else begin
                len = $urandom_range(1, 6);
                for (int j = 0; j < len && cnt < n; j++) begin
                    case ($urandom_range(0, 3))
                        0: add_sample(32767);
                        1: add_sample(-32768);
                        2: add_sample(0);
                        default: add_sample(-1);
                    endcase
                    cnt++;
                end
            end
        end
    endtask

    task automatic run_phase(input logic [ALPHA_BITS-1:0] alpha, input int n);
        write_decay(alpha);
        gen_signal(n);
        drain();
    endtask

    initial begin
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, no decay: zero span first, then the full-scale extremes,
        // a sample on the maximum (ratio +1.0, saturates) and on the minimum
        write_decay('0);
        add_sample(0);
        add_sample(0);
        add_sample(32767);
        add_sample(-32768);
        add_sample(32767);
        add_sample(-32768);
        add_sample(0);
        add_sample(1);
        add_sample(-1);
        add_sample(12345);
        drain();

        // Full half-step decay collapses a constant input to zero span
        write_decay(16'd32768);
        add_sample(500);
        add_sample(500);
        add_sample(500);
        add_sample(-32768);
        add_sample(32767);
        add_sample(32767);
        drain();

        // Alpha above one half: extremes cross and the span goes negative
        write_decay(16'hFFFF);
        add_sample(100);
        add_sample(-100);
        add_sample(50);
        add_sample(0);
        add_sample(0);
        add_sample(-20000);
        add_sample(30000);
        add_sample(7);
        drain();

        // Random part across several decay settings, extremes among them
        run_phase(16'd32768, 105);
        run_phase(16'd1, 105);
        run_phase(16'd256, 105);
        run_phase(16'd4096, 105);
        run_phase(16'hFFFF, 100);
        run_phase(16'd40000, 100);
        run_phase('0, 105);
        run_phase(16'($urandom_range(0, 32768)), 100);
        run_phase(16'($urandom_range(0, 32768)), 100);
        run_phase(16'd32768, 100);

        drain();
        if (norm_expect_q.size() != 0) begin
            $error("%0d results never arrived", norm_expect_q.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Drop the run if it hangs
    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
design/aen_pkg.sv
design/aen_ctrl.sv
design/aen_dp.sv
design/ask_envelope_normalizer_top.sv
test/tb.sv
